// ===== rtl/admitted_sender_window_average_assert.svh =====
// Concurrent check macros, clocked on clk and held off during rst.
`ifndef ADMITTED_SENDER_WINDOW_AVERAGE_ASSERT_SVH
`define ADMITTED_SENDER_WINDOW_AVERAGE_ASSERT_SVH

// Same-cycle implication.
`define ASD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/asd_pkg.sv =====
package asd_pkg;

  localparam int ADDR_W      = 64;
  localparam int READING_W   = 32;
  localparam int CNT_FIELD_W = 4;

  typedef struct packed {
    logic [ADDR_W-1:0]           sender_addr_high;
    logic [ADDR_W-1:0]           sender_addr_low;
    logic signed [READING_W-1:0] reading;
  } in_t;

  typedef struct packed {
    logic                        accepted;
    logic                        new_sender;
    logic signed [READING_W-1:0] average;
    logic                        average_valid;
    logic [CNT_FIELD_W-1:0]      nonzero_count;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_COMPARE,
    ST_DECIDE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic latch;
    logic compare;
    logic admit;
    logic reject;
    logic ring_write;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic walk_done;
    logic found;
    logic full;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/asd_ram.sv =====
module asd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/asd_ctrl.sv =====
module asd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output asd_pkg::cmd_t cmd,
  input  asd_pkg::sts_t sts
);
  import asd_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_READ;
      end
      ST_READ: begin
        if (sts.walk_done || sts.found) state_next = ST_DECIDE;
        else state_next = ST_COMPARE;
      end
      ST_COMPARE: begin
        state_next = ST_READ;
      end
      ST_DECIDE: begin
        if (!sts.found && sts.full) state_next = ST_DONE;
        else state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (sts.div_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      ST_COMPARE: begin
        cmd.compare = 1'b1;
      end
      ST_DECIDE: begin
        if (!sts.found && sts.full) begin
          cmd.reject = 1'b1;
        end else begin
          cmd.admit = !sts.found;
        end
      end
      ST_UPDATE: begin
        cmd.ring_write = 1'b1;
      end
      ST_DIVIDE: begin
        cmd.div_step = !sts.div_done;
      end
      ST_DONE: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/asd_datapath.sv =====
module asd_datapath #(
  parameter int MAX_SENDERS   = 10,
  parameter int WINDOW_LENGTH = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  asd_pkg::in_t  in_data,
  input  asd_pkg::cmd_t cmd,
  output asd_pkg::sts_t sts,
  output logic          out_valid,
  input  logic          out_ready,
  output asd_pkg::out_t out_data
);
  import asd_pkg::*;

  localparam int SAW = (MAX_SENDERS > 1) ? $clog2(MAX_SENDERS) : 1;
  localparam int SCW = $clog2(MAX_SENDERS + 1);
  localparam int RAW = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int CW  = $clog2(WINDOW_LENGTH + 1);
  localparam int SW  = READING_W + $clog2(WINDOW_LENGTH);
  localparam int DSW = $clog2(SW + 1);
  localparam int KW  = 2 * ADDR_W;

  in_t                         req;
  logic [SCW-1:0]              idx;
  logic                        found;
  logic                        added;
  logic                        rejected;
  logic [SCW-1:0]              sender_count;
  logic [RAW-1:0]              write_slot;
  logic [WINDOW_LENGTH-1:0]    ring_valid;
  logic signed [SW-1:0]        win_sum;
  logic [CW-1:0]               win_count;
  logic                        sum_neg;
  logic [SW-1:0]               div_q;
  logic [CW-1:0]               div_r;
  logic [DSW-1:0]              div_n;

  logic [KW-1:0]               tbl_rdata;
  logic [READING_W-1:0]        ring_rdata;
  logic signed [READING_W-1:0] old_val;
  logic signed [SW-1:0]        win_sum_next;
  logic [CW-1:0]               win_count_next;
  logic [CW:0]                 rem_shift;
  logic [CW:0]                 div_ext;
  logic                        q_bit;
  logic [SW-1:0]               quot_signed;

  asd_ram #(.WIDTH(KW), .DEPTH(MAX_SENDERS)) u_sender_ram (
    .clk   (clk),
    .we    (cmd.admit),
    .waddr (sender_count[SAW-1:0]),
    .wdata ({req.sender_addr_high, req.sender_addr_low}),
    .raddr (idx[SAW-1:0]),
    .rdata (tbl_rdata)
  );

  asd_ram #(.WIDTH(READING_W), .DEPTH(WINDOW_LENGTH)) u_ring_ram (
    .clk   (clk),
    .we    (cmd.ring_write),
    .waddr (write_slot),
    .wdata (req.reading),
    .raddr (write_slot),
    .rdata (ring_rdata)
  );

  // Slots never written read as zero.
  assign old_val = ring_valid[write_slot] ? $signed(ring_rdata) : '0;

  assign win_sum_next   = win_sum - SW'(old_val) + SW'(req.reading);
  assign win_count_next = win_count - CW'(old_val != '0) + CW'(req.reading != '0);

  assign rem_shift   = {div_r, div_q[SW-1]};
  assign div_ext     = {1'b0, win_count};
  assign q_bit       = (rem_shift >= div_ext);
  assign quot_signed = sum_neg ? (~div_q + SW'(1)) : div_q;

  always_comb begin
    sts.walk_done = (idx >= sender_count);
    sts.found     = found;
    sts.full      = (sender_count == SCW'(MAX_SENDERS));
    sts.div_done  = (div_n == DSW'(SW));
    sts.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sender_count <= '0;
      write_slot   <= '0;
      ring_valid   <= '0;
      win_sum      <= '0;
      win_count    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.admit) begin
        sender_count <= sender_count + SCW'(1);
      end
      if (cmd.ring_write) begin
        ring_valid[write_slot] <= 1'b1;
        win_sum                <= win_sum_next;
        win_count              <= win_count_next;
        if (write_slot == RAW'(WINDOW_LENGTH - 1)) write_slot <= '0;
        else write_slot <= write_slot + RAW'(1);
      end
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req      <= in_data;
      idx      <= '0;
      found    <= 1'b0;
      added    <= 1'b0;
      rejected <= 1'b0;
    end
    if (cmd.compare) begin
      if (tbl_rdata == {req.sender_addr_high, req.sender_addr_low}) found <= 1'b1;
      idx <= idx + SCW'(1);
    end
    if (cmd.admit) added <= 1'b1;
    if (cmd.reject) rejected <= 1'b1;
    // Load the divider with the magnitude of the new window sum.
    if (cmd.ring_write) begin
      sum_neg <= win_sum_next[SW-1];
      div_q   <= win_sum_next[SW-1] ? SW'(-win_sum_next) : SW'(win_sum_next);
      div_r   <= '0;
      div_n   <= '0;
    end
    if (cmd.div_step) begin
      div_r <= q_bit ? CW'(rem_shift - div_ext) : rem_shift[CW-1:0];
      div_q <= {div_q[SW-2:0], q_bit};
      div_n <= div_n + DSW'(1);
    end
    if (cmd.load_out) begin
      if (rejected || win_count == '0) begin
        out_data.average       <= '0;
        out_data.average_valid <= 1'b0;
      end else begin
        out_data.average       <= $signed(quot_signed[READING_W-1:0]);
        out_data.average_valid <= 1'b1;
      end
      out_data.accepted      <= !rejected;
      out_data.new_sender    <= added && !rejected;
      out_data.nonzero_count <= rejected ? '0 : CNT_FIELD_W'(win_count);
    end
  end

endmodule

// ===== rtl/admitted_sender_window_average.sv =====
// Each request is taken, then the table walk scans S sender entries; a request whose
// sender is unknown while the table is full is rejected, else the window is updated and
// the bit-serial divider runs SW = 32 + clog2(WINDOW_LENGTH) steps before the result is loaded.
// The table walk and the bit-serial divider set the rate; no new request is taken until
// the last result is loaded. The next request is taken while the result waits in its
// register. Reset (synchronous): table and window empty, no result.
module admitted_sender_window_average #(
  parameter int MAX_SENDERS   = 10,
  parameter int WINDOW_LENGTH = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  asd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output asd_pkg::out_t out_data
);
  import asd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  asd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  asd_datapath #(
    .MAX_SENDERS   (MAX_SENDERS),
    .WINDOW_LENGTH (WINDOW_LENGTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/asd_chk.sv =====
`include "admitted_sender_window_average_assert.svh"

module asd_chk (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input asd_pkg::out_t out_data
);

  `ASD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped or changed while stalled")
  `ASD_ASSERT_NOW(a_reject_zero, out_valid && !out_data.accepted, !out_data.new_sender && !out_data.average_valid && out_data.average == 0 && out_data.nonzero_count == 0, "rejected result not all zero")
  `ASD_ASSERT_NOW(a_count_valid, out_valid && out_data.accepted && out_data.nonzero_count != 0, out_data.average_valid, "nonzero count without valid average")
  `ASD_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "request taken while one is in flight")

endmodule

bind admitted_sender_window_average asd_chk u_asd_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
